// File: src/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int TTL_W  = 32;
    localparam int TICK_W = 48;
    localparam int ACT_W  = 2;
    localparam int FT_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 3;

    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1000);

    localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FRAME = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    localparam logic [FT_W-1:0] FT_IP      = 2'd0;
    localparam logic [FT_W-1:0] FT_ARP_REQ = 2'd1;
    localparam logic [FT_W-1:0] FT_ARP_REP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TTL = 1'd1;

    localparam logic [MAC_W-1:0] MAC_BCAST = '1;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        ITEM_DROP,
        ITEM_SEND,
        ITEM_TICK,
        ITEM_UP,
        ITEM_ARP_REQ,
        ITEM_ARP_REP
    } item_t;

    typedef enum logic [1:0] {
        RES_FWD,
        RES_ARP_REQ,
        RES_UP,
        RES_ARP_REP
    } res_t;

    typedef struct packed {
        logic load_item;
        logic tick_inc;
        logic set_host;
        logic scan_clr;
        logic scan_rd;
        logic clr_valid;
        logic wr_exp;
        logic wr_new;
        logic emit;
        res_t res;
    } cmd_t;

    typedef struct packed {
        item_t kind;
        logic  last_addr;
        logic  found;
        logic  live;
        logic  free_found;
        logic  out_free;
    } sts_t;

endpackage
`default_nettype wire

// File: src/arp_cache_resolver.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------
// s_        | s_tvalid / s_tready  | tdata: dst_mac, src_mac, src_ip, dst_ip;
//           |                      | tuser: action, frame_type
// m_        | m_tvalid / m_tready  | tdata: out_dst_mac, out_src_mac, out_src_ip,
//           |                      | out_dst_ip; tuser: to_ip_layer, out_type
// cfg_      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. A send or an ARP reply scans the cache one entry per cycle
// through a single read port.
// A tick, a delivered IP frame or an answered ARP request takes no scan.
// Reset clears the valid bits, tick count and host IP; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
// and its own result stalls until the output register frees up.
`default_nettype none
module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // dst_mac[47:0], src_mac[95:48], src_ip[127:96], dst_ip[159:128]
    input  wire logic [arpc_pkg::IN_DATA_W-1:0]  s_tdata,
    // action[1:0], frame_type[3:2]
    input  wire logic [arpc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_dst_mac[47:0], out_src_mac[95:48], out_src_ip[127:96], out_dst_ip[159:128]
    output logic [arpc_pkg::OUT_DATA_W-1:0]      m_tdata,
    // to_ip_layer[0], out_type[2:1]
    output logic [arpc_pkg::OUT_USER_W-1:0]      m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

// File: src/arpc_ctrl.sv
`default_nettype none
module arpc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire arpc_pkg::sts_t sts,
    output arpc_pkg::cmd_t     cmd
);
    import arpc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DISP   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_LAST   = 6'b001000,
        S_DECIDE = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_FWD;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.res    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.kind)
                    ITEM_SEND:
                    begin
                        cmd.set_host = 1'b1;
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                    ITEM_ARP_REP:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN;
                    end
                    ITEM_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = S_IDLE;
                    end
                    ITEM_UP:
                    begin
                        res_next   = RES_UP;
                        state_next = S_EMIT;
                    end
                    ITEM_ARP_REQ:
                    begin
                        res_next   = RES_ARP_REP;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.kind == ITEM_SEND)
                begin
                    if (sts.found && sts.live)
                    begin
                        res_next = RES_FWD;
                    end
                    else
                    begin
                        cmd.clr_valid = sts.found;
                        res_next      = RES_ARP_REQ;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.wr_exp = sts.found;
                    cmd.wr_new = !sts.found && sts.free_found;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/arpc_datapath.sv
`default_nettype none
module arpc_datapath #(
    parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [arpc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic [arpc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [arpc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [arpc_pkg::OUT_USER_W-1:0]      m_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire arpc_pkg::cmd_t                  cmd,
    output arpc_pkg::sts_t                       sts
);
    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

    logic [MAC_W-1:0]  own_mac_reg;
    logic [TTL_W-1:0]  ttl_reg;
    logic [IP_W-1:0]   host_ip_reg;
    logic [TICK_W-1:0] tick_reg;

    logic [ACT_W-1:0]  it_act_reg;
    logic [FT_W-1:0]   it_ft_reg;
    logic [MAC_W-1:0]  it_dmac_reg;
    logic [MAC_W-1:0]  it_smac_reg;
    logic [IP_W-1:0]   it_sip_reg;
    logic [IP_W-1:0]   it_dip_reg;

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [IP_W-1:0]   ip_mem  [CACHE_ENTRIES];
    logic [MAC_W-1:0]  mac_mem [CACHE_ENTRIES];
    logic [TICK_W-1:0] exp_mem [CACHE_ENTRIES];
    logic [IP_W-1:0]   rd_ip_reg;
    logic [MAC_W-1:0]  rd_mac_reg;
    logic [TICK_W-1:0] rd_exp_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic              cmp_en_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [MAC_W-1:0]  hit_mac_reg;
    logic [TICK_W-1:0] hit_exp_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    logic                  out_valid_reg;
    logic                  out_up_reg;
    logic [FT_W-1:0]       out_type_reg;
    logic [MAC_W-1:0]      out_dmac_reg;
    logic [MAC_W-1:0]      out_smac_reg;
    logic [IP_W-1:0]       out_sip_reg;
    logic [IP_W-1:0]       out_dip_reg;

    item_t             kind;
    logic [IP_W-1:0]   key;
    logic              cmp_valid;
    logic              cmp_hit;
    logic [TICK_W:0]   exp_sum;
    logic [TICK_W-1:0] exp_new;
    logic [IDX_W-1:0]  wr_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            ttl_reg     <= TTL_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_OWN_MAC)
            begin
                own_mac_reg <= cfg_data[MAC_W-1:0];
            end
            else if (cfg_index == REG_ENTRY_TTL)
            begin
                ttl_reg <= cfg_data[TTL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            it_act_reg  <= s_tuser[ACT_W-1:0];
            it_ft_reg   <= s_tuser[ACT_W+FT_W-1:ACT_W];
            it_dmac_reg <= s_tdata[MAC_W-1:0];
            it_smac_reg <= s_tdata[2*MAC_W-1:MAC_W];
            it_sip_reg  <= s_tdata[2*MAC_W+IP_W-1:2*MAC_W];
            it_dip_reg  <= s_tdata[2*MAC_W+2*IP_W-1:2*MAC_W+IP_W];
        end
    end

    always_comb
    begin
        kind = ITEM_DROP;
        priority if (it_act_reg == ACT_SEND)
        begin
            kind = ITEM_SEND;
        end
        else if (it_act_reg == ACT_TICK)
        begin
            kind = ITEM_TICK;
        end
        else if (it_act_reg == ACT_FRAME)
        begin
            priority if (it_ft_reg == FT_IP && it_dmac_reg == own_mac_reg)
            begin
                kind = ITEM_UP;
            end
            else if (it_ft_reg == FT_ARP_REQ && it_dip_reg == host_ip_reg)
            begin
                kind = ITEM_ARP_REQ;
            end
            else if (it_ft_reg == FT_ARP_REP && it_dmac_reg == own_mac_reg)
            begin
                kind = ITEM_ARP_REP;
            end
            else
            begin
                kind = ITEM_DROP;
            end
        end
        else
        begin
            kind = ITEM_DROP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_ip_reg <= '0;
            tick_reg    <= '0;
        end
        else
        begin
            if (cmd.set_host)
            begin
                host_ip_reg <= it_sip_reg;
            end
            if (cmd.tick_inc && tick_reg != TICK_MAX)
            begin
                tick_reg <= tick_reg + TICK_W'(1);
            end
        end
    end

    assign key       = (kind == ITEM_SEND) ? it_dip_reg : it_sip_reg;
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_hit   = cmp_en_reg && cmp_valid && rd_ip_reg == key;
    assign exp_sum   = {1'b0, tick_reg} + {{(TICK_W+1-TTL_W){1'b0}}, ttl_reg};
    assign exp_new   = exp_sum[TICK_W] ? TICK_MAX : exp_sum[TICK_W-1:0];
    assign wr_idx    = cmd.wr_new ? free_idx_reg : hit_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_ip_reg  <= ip_mem[cnt_reg];
            rd_mac_reg <= mac_mem[cnt_reg];
            rd_exp_reg <= exp_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new)
        begin
            ip_mem[wr_idx]  <= it_sip_reg;
            mac_mem[wr_idx] <= it_smac_reg;
        end
        if (cmd.wr_new || cmd.wr_exp)
        begin
            exp_mem[wr_idx] <= exp_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_new)
        begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
        else if (cmd.clr_valid)
        begin
            valid_reg[hit_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            cmp_en_reg     <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg  <= cmd.scan_rd;
            cmp_idx_reg <= cnt_reg;
            if (cmd.scan_clr)
            begin
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                if (cmp_hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (cmp_en_reg && !cmp_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_hit && !found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_mac_reg <= rd_mac_reg;
            hit_exp_reg <= rd_exp_reg;
        end
        if (cmp_en_reg && !cmp_valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            unique case (cmd.res)
                RES_FWD:
                begin
                    out_up_reg   <= 1'b0;
                    out_type_reg <= FT_IP;
                    out_dmac_reg <= hit_mac_reg;
                    out_smac_reg <= own_mac_reg;
                    out_sip_reg  <= it_sip_reg;
                    out_dip_reg  <= it_dip_reg;
                end
                RES_ARP_REQ:
                begin
                    out_up_reg   <= 1'b0;
                    out_type_reg <= FT_ARP_REQ;
                    out_dmac_reg <= MAC_BCAST;
                    out_smac_reg <= own_mac_reg;
                    out_sip_reg  <= it_sip_reg;
                    out_dip_reg  <= it_dip_reg;
                end
                RES_UP:
                begin
                    out_up_reg   <= 1'b1;
                    out_type_reg <= FT_IP;
                    out_dmac_reg <= it_dmac_reg;
                    out_smac_reg <= it_smac_reg;
                    out_sip_reg  <= it_sip_reg;
                    out_dip_reg  <= it_dip_reg;
                end
                RES_ARP_REP:
                begin
                    out_up_reg   <= 1'b0;
                    out_type_reg <= FT_ARP_REP;
                    out_dmac_reg <= it_smac_reg;
                    out_smac_reg <= own_mac_reg;
                    out_sip_reg  <= it_dip_reg;
                    out_dip_reg  <= it_sip_reg;
                end
                default:
                begin
                    out_up_reg   <= 1'b0;
                    out_type_reg <= FT_IP;
                    out_dmac_reg <= it_dmac_reg;
                    out_smac_reg <= it_smac_reg;
                    out_sip_reg  <= it_sip_reg;
                    out_dip_reg  <= it_dip_reg;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dip_reg, out_sip_reg, out_smac_reg, out_dmac_reg};
    assign m_tuser  = {out_type_reg, out_up_reg};

    assign sts.kind       = kind;
    assign sts.last_addr  = (cnt_reg == IDX_LAST);
    assign sts.found      = found_reg;
    assign sts.live       = (hit_exp_reg >= tick_reg);
    assign sts.free_found = free_found_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

// File: src/arpc_checker.sv
`default_nettype none
module arpc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [arpc_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [arpc_pkg::OUT_USER_W-1:0] m_tuser
);
    import arpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_up_is_ip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == FT_IP)
        else $error("upward delivery that is not an IP frame");

    a_req_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:1] == FT_ARP_REQ |-> m_tdata[MAC_W-1:0] == MAC_BCAST
            && !m_tuser[0])
        else $error("ARP request not broadcast");

    a_type_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:1] == FT_IP || m_tuser[2:1] == FT_ARP_REQ
            || m_tuser[2:1] == FT_ARP_REP)
        else $error("unknown frame type on output");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
